// ===== src/esf_pkg.sv =====
// Shared constants for the encoder speed trimmed-mean filter.
// Used by esf_div, the top level and the port checker; depends on nothing.
`default_nettype none

package esf_pkg;

    localparam int WINDOW_SIZE    = 10;
    localparam int TRIM_EACH_SIDE = 2;
    localparam int TRIM_EFF       = (2 * TRIM_EACH_SIDE >= WINDOW_SIZE) ?
                                    (WINDOW_SIZE - 1) / 2 : TRIM_EACH_SIDE;
    localparam int AVG_CNT        = WINDOW_SIZE - 2 * TRIM_EFF;
    localparam int IDX_W          = $clog2(WINDOW_SIZE);
    localparam int SUM_W          = 32 + $clog2(WINDOW_SIZE);

    localparam int DATA_W         = 32;
    localparam int CFG_W          = 16;
    localparam int DIV_W          = 57;
    localparam int DIV_CNT_W      = $clog2(DIV_W + 1);
    localparam int PROD_W         = 49;
    localparam int FILT_W         = 36;
    localparam int GEAR_FRAC      = 16;
    localparam int ENC_LIMIT_LOG2 = 40;

    localparam logic signed [16:0] RPM_SCALE  = 17'sd60000;
    localparam logic [CFG_W-1:0]   FILT_DEN   = 16'd10;
    localparam logic [CFG_W-1:0]   CPR_RESET  = 16'd52;
    localparam logic [CFG_W-1:0]   GEAR_RESET = 16'd256;

    localparam logic CFG_COUNTS_PER_REV = 1'b0;
    localparam logic CFG_GEAR_RATIO     = 1'b1;

endpackage

`default_nettype wire

// ===== src/encoder_speed_trimmed_mean_filter.sv =====
// Top level of the encoder speed trimmed-mean filter: sequencer, sample line, sorter.
// Depends on esf_pkg and instantiates esf_div.
`default_nettype none

// Each accepted position gives one rpm sample: the position change times 60000 is
// divided by counts_per_rev, limited, shifted to Q16 and divided by gear_ratio, all
// through one shared radix-2 divider of 57 steps. An ordinary transaction holds the
// input stalled for two divisions and the sequencing states around them.
// Every tenth transaction also sorts the window with one compare-exchange unit
// (9 passes) and runs two more divisions for the trimmed mean and the low pass,
// stalling the input longer while an earlier result still waits at the output;
// only that transaction produces a result.
// The result waits in an output register, and the block accepts new positions
// while it is held.
module encoder_speed_trimmed_mean_filter (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [esf_pkg::DATA_W-1:0]  i_position_count,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [esf_pkg::DATA_W-1:0]       o_filtered_speed,
    output logic signed [esf_pkg::DATA_W-1:0]       o_trimmed_mean_speed,
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_idx,
    input  wire logic [esf_pkg::CFG_W-1:0]          i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE, S_RPM_GO, S_RPM_WAIT, S_GEAR_GO, S_GEAR_WAIT,
        S_FLUSH, S_CMP, S_AVG_GO, S_AVG_WAIT, S_FILT_GO, S_FILT_WAIT, S_EMIT
    } t_state;

    localparam int NL = esf_pkg::WINDOW_SIZE - 1;
    localparam logic [esf_pkg::DIV_W-1:0] ENC_LIMIT =
        esf_pkg::DIV_W'(1) << esf_pkg::ENC_LIMIT_LOG2;
    localparam logic [esf_pkg::DIV_W-1:0] SAT_POS = (esf_pkg::DIV_W'(1) << 31) - 1'b1;
    localparam logic [esf_pkg::DIV_W-1:0] SAT_NEG = esf_pkg::DIV_W'(1) << 31;

    t_state                                r_state, n_state;
    logic [esf_pkg::CFG_W-1:0]             r_cpr, n_cpr;
    logic [esf_pkg::CFG_W-1:0]             r_gear, n_gear;
    logic signed [esf_pkg::DATA_W-1:0]     r_last, n_last;
    logic signed [esf_pkg::DATA_W-1:0]     r_filt_mem, n_filt_mem;
    logic [esf_pkg::IDX_W-1:0]             r_idx, n_idx;
    logic [esf_pkg::IDX_W-1:0]             r_pass, n_pass;
    logic [esf_pkg::IDX_W-1:0]             r_step, n_step;
    logic                                  r_out_valid, n_out_valid;

    logic signed [32:0]                    r_delta, n_delta;
    logic signed [esf_pkg::PROD_W-1:0]     r_prod, n_prod;
    logic                                  r_neg, n_neg;
    logic signed [esf_pkg::DATA_W-1:0]     r_line [NL], n_line [NL];
    logic signed [esf_pkg::DATA_W-1:0]     r_hold, n_hold;
    logic signed [esf_pkg::SUM_W-1:0]      r_sum, n_sum;
    logic signed [esf_pkg::DATA_W-1:0]     r_avg, n_avg;
    logic signed [esf_pkg::DATA_W-1:0]     r_filtered, n_filtered;
    logic signed [esf_pkg::DATA_W-1:0]     r_trimmed, n_trimmed;

    logic                                  w_div_start;
    logic [esf_pkg::DIV_W-1:0]             w_div_dividend;
    logic [esf_pkg::CFG_W-1:0]             w_div_divisor;
    logic                                  w_div_done;
    logic [esf_pkg::DIV_W-1:0]             w_div_quo;

    logic signed [esf_pkg::PROD_W-1:0]     w_prod_full;
    logic signed [esf_pkg::PROD_W-1:0]     w_prod_mag;
    logic signed [esf_pkg::SUM_W-1:0]      w_sum_mag;
    logic signed [esf_pkg::FILT_W-1:0]     w_avg_x, w_old_x, w_filt, w_filt_mag;
    logic [esf_pkg::DIV_W-1:0]             w_clamp;
    logic [esf_pkg::CFG_W-1:0]             w_cpr_eff, w_gear_eff;
    logic signed [esf_pkg::DATA_W-1:0]     w_motor, w_mn, w_mx, w_qs;
    logic                                  w_last_pass, w_in_mn, w_in_mx;

    esf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    always_comb begin
        w_prod_full = r_delta * esf_pkg::RPM_SCALE;
        w_prod_mag  = r_prod[esf_pkg::PROD_W-1] ? -r_prod : r_prod;
        w_sum_mag   = r_sum[esf_pkg::SUM_W-1] ? -r_sum : r_sum;
        w_avg_x     = esf_pkg::FILT_W'(r_avg);
        w_old_x     = esf_pkg::FILT_W'(r_filt_mem);
        w_filt      = (w_avg_x <<< 1) + w_avg_x + (w_old_x <<< 3) - w_old_x;
        w_filt_mag  = w_filt[esf_pkg::FILT_W-1] ? -w_filt : w_filt;
        w_clamp     = (w_div_quo > ENC_LIMIT) ? ENC_LIMIT : w_div_quo;
        w_cpr_eff   = (r_cpr == '0) ? esf_pkg::CFG_W'(1) : r_cpr;
        w_gear_eff  = (r_gear == '0) ? esf_pkg::CFG_W'(1) : r_gear;
        w_qs        = r_neg ? -w_div_quo[esf_pkg::DATA_W-1:0]
                            : w_div_quo[esf_pkg::DATA_W-1:0];

        if (!r_neg) begin
            w_motor = (w_div_quo > SAT_POS) ? SAT_POS[esf_pkg::DATA_W-1:0]
                                            : w_div_quo[esf_pkg::DATA_W-1:0];
        end else begin
            w_motor = (w_div_quo > SAT_NEG) ? SAT_NEG[esf_pkg::DATA_W-1:0]
                                            : -w_div_quo[esf_pkg::DATA_W-1:0];
        end

        w_mn        = (r_line[0] < r_hold) ? r_line[0] : r_hold;
        w_mx        = (r_line[0] < r_hold) ? r_hold : r_line[0];
        w_last_pass = (r_pass == esf_pkg::IDX_W'(NL - 1));
        w_in_mn     = w_last_pass && (r_step >= esf_pkg::IDX_W'(esf_pkg::TRIM_EFF))
                      && (r_step <= esf_pkg::IDX_W'(NL - esf_pkg::TRIM_EFF));
        w_in_mx     = w_last_pass && (r_step == esf_pkg::IDX_W'(NL - 1))
                      && (esf_pkg::TRIM_EFF == 0);

        w_div_start    = 1'b0;
        w_div_dividend = '0;
        w_div_divisor  = w_cpr_eff;
        case (r_state)
            S_RPM_GO: begin
                w_div_start    = 1'b1;
                w_div_dividend = esf_pkg::DIV_W'($unsigned(w_prod_mag));
                w_div_divisor  = w_cpr_eff;
            end
            S_GEAR_GO: begin
                w_div_start    = 1'b1;
                w_div_dividend = {w_clamp[esf_pkg::DIV_W-esf_pkg::GEAR_FRAC-1:0],
                                  esf_pkg::GEAR_FRAC'(0)};
                w_div_divisor  = w_gear_eff;
            end
            S_AVG_GO: begin
                w_div_start    = 1'b1;
                w_div_dividend = esf_pkg::DIV_W'($unsigned(w_sum_mag));
                w_div_divisor  = esf_pkg::CFG_W'(esf_pkg::AVG_CNT);
            end
            S_FILT_GO: begin
                w_div_start    = 1'b1;
                w_div_dividend = esf_pkg::DIV_W'($unsigned(w_filt_mag));
                w_div_divisor  = esf_pkg::FILT_DEN;
            end
            default: begin
                w_div_start    = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cpr       = r_cpr;
        n_gear      = r_gear;
        n_last      = r_last;
        n_filt_mem  = r_filt_mem;
        n_idx       = r_idx;
        n_pass      = r_pass;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_delta     = r_delta;
        n_prod      = r_prod;
        n_neg       = r_neg;
        n_line      = r_line;
        n_hold      = r_hold;
        n_sum       = r_sum;
        n_avg       = r_avg;
        n_filtered  = r_filtered;
        n_trimmed   = r_trimmed;

        if (i_cfg_we) begin
            if (i_cfg_idx == esf_pkg::CFG_COUNTS_PER_REV) begin
                n_cpr = i_cfg_data;
            end else begin
                n_gear = i_cfg_data;
            end
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_delta = {i_position_count[31], i_position_count}
                              - {r_last[31], r_last};
                    n_last  = i_position_count;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_prod  = w_prod_full;
                n_state = S_RPM_GO;
            end
            S_RPM_GO: begin
                n_neg   = r_prod[esf_pkg::PROD_W-1];
                n_state = S_RPM_WAIT;
            end
            S_RPM_WAIT: begin
                if (w_div_done) begin
                    n_state = S_GEAR_GO;
                end
            end
            S_GEAR_GO: begin
                n_state = S_GEAR_WAIT;
            end
            S_GEAR_WAIT: begin
                if (w_div_done) begin
                    for (int i = 0; i < NL - 1; i++) begin
                        n_line[i] = r_line[i+1];
                    end
                    n_line[NL-1] = r_hold;
                    n_hold       = w_motor;
                    if (r_idx == esf_pkg::IDX_W'(NL)) begin
                        n_idx   = '0;
                        n_pass  = '0;
                        n_sum   = '0;
                        n_state = S_FLUSH;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                for (int i = 0; i < NL - 1; i++) begin
                    n_line[i] = r_line[i+1];
                end
                n_line[NL-1] = r_hold;
                n_hold       = r_line[0];
                n_step       = '0;
                n_state      = S_CMP;
            end
            S_CMP: begin
                for (int i = 0; i < NL - 1; i++) begin
                    n_line[i] = r_line[i+1];
                end
                n_line[NL-1] = w_mn;
                n_hold       = w_mx;
                n_sum        = r_sum
                               + (w_in_mn ? esf_pkg::SUM_W'(w_mn) : esf_pkg::SUM_W'(0))
                               + (w_in_mx ? esf_pkg::SUM_W'(w_mx) : esf_pkg::SUM_W'(0));
                n_step       = r_step + 1'b1;
                if (r_step == esf_pkg::IDX_W'(NL - 1)) begin
                    if (w_last_pass) begin
                        n_state = S_AVG_GO;
                    end else begin
                        n_pass  = r_pass + 1'b1;
                        n_state = S_FLUSH;
                    end
                end
            end
            S_AVG_GO: begin
                n_neg   = r_sum[esf_pkg::SUM_W-1];
                n_state = S_AVG_WAIT;
            end
            S_AVG_WAIT: begin
                if (w_div_done) begin
                    n_avg   = w_qs;
                    n_state = S_FILT_GO;
                end
            end
            S_FILT_GO: begin
                n_neg   = w_filt[esf_pkg::FILT_W-1];
                n_state = S_FILT_WAIT;
            end
            S_FILT_WAIT: begin
                if (w_div_done) begin
                    n_filt_mem = w_qs;
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_filtered  = r_filt_mem;
                    n_trimmed   = r_avg;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cpr       <= esf_pkg::CPR_RESET;
            r_gear      <= esf_pkg::GEAR_RESET;
            r_last      <= '0;
            r_filt_mem  <= '0;
            r_idx       <= '0;
            r_pass      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_filtered  <= '0;
            r_trimmed   <= '0;
        end else begin
            r_state     <= n_state;
            r_cpr       <= n_cpr;
            r_gear      <= n_gear;
            r_last      <= n_last;
            r_filt_mem  <= n_filt_mem;
            r_idx       <= n_idx;
            r_pass      <= n_pass;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_filtered  <= n_filtered;
            r_trimmed   <= n_trimmed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_delta    <= n_delta;
        r_prod     <= n_prod;
        r_neg      <= n_neg;
        r_line     <= n_line;
        r_hold     <= n_hold;
        r_sum      <= n_sum;
        r_avg      <= n_avg;
    end

    assign o_in_stall           = (r_state != S_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_filtered_speed     = r_filtered;
    assign o_trimmed_mean_speed = r_trimmed;

endmodule

`default_nettype wire

// ===== src/esf_div.sv =====
// Radix-2 restoring divider, unsigned, one quotient bit per clock.
// Depends on esf_pkg for the dividend and divisor widths.
`default_nettype none

module esf_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [esf_pkg::DIV_W-1:0]     i_dividend,
    input  wire logic [esf_pkg::CFG_W-1:0]     i_divisor,
    output logic                               o_done,
    output logic [esf_pkg::DIV_W-1:0]          o_quotient
);

    logic [esf_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_done;
    logic [esf_pkg::DIV_W-1:0]     r_quo;
    logic [esf_pkg::CFG_W-1:0]     r_rem;
    logic [esf_pkg::CFG_W-1:0]     r_dsr;

    logic [esf_pkg::CFG_W:0]       w_trial;
    logic [esf_pkg::CFG_W-1:0]     w_diff;
    logic                          w_fit;

    always_comb begin
        w_trial = {r_rem, r_quo[esf_pkg::DIV_W-1]};
        w_diff  = w_trial[esf_pkg::CFG_W-1:0] - r_dsr;
        w_fit   = (w_trial >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= esf_pkg::DIV_CNT_W'(esf_pkg::DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == esf_pkg::DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[esf_pkg::DIV_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff : w_trial[esf_pkg::CFG_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== src/esf_chk.sv =====
// Port checker for the encoder speed trimmed-mean filter, bound to the top level.
// Depends on esf_pkg for the field widths.
`default_nettype none

module esf_chk (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire logic                               o_in_stall,
    input  wire logic                               o_out_valid,
    input  wire logic                               i_out_stall,
    input  wire logic signed [esf_pkg::DATA_W-1:0]  o_filtered_speed,
    input  wire logic signed [esf_pkg::DATA_W-1:0]  o_trimmed_mean_speed
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transaction");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_filtered_speed)
                                          && $stable(o_trimmed_mean_speed)))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind encoder_speed_trimmed_mean_filter esf_chk u_esf_chk (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in_valid),
    .o_in_stall           (o_in_stall),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_filtered_speed     (o_filtered_speed),
    .o_trimmed_mean_speed (o_trimmed_mean_speed)
);

`default_nettype wire
